### hw/rtl/serial_command_frame_parser_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the serial command frame parser checks.
// ----------------------------------------------------------------------------
`ifndef SERIAL_COMMAND_FRAME_PARSER_ASSERT_SVH
`define SERIAL_COMMAND_FRAME_PARSER_ASSERT_SVH

// Check that is switched off while reset is high.
`define SCFP_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("scfp check failed");

// Check that also holds across reset.
`define SCFP_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("scfp check failed");

`endif

### hw/rtl/scfp_pkg.sv
// ----------------------------------------------------------------------------
// scfp_pkg
// Types and constants shared by the serial command frame parser files.
// ----------------------------------------------------------------------------
`default_nettype none

package scfp_pkg;

  // One input beat: a received byte or the ratio-test-done marker.
  typedef struct packed {
    logic       mode;
    logic [7:0] rx_byte;
  } in_t;

  // One result beat: the event code and the captured bytes.
  typedef struct packed {
    logic [3:0] event_res;
    logic [7:0] sync_hour;
    logic [7:0] sync_minute;
    logic [7:0] sync_second;
    logic [7:0] sync_day;
    logic [7:0] sync_month;
    logic [7:0] sync_year;
    logic [7:0] alarm_hour;
    logic [7:0] alarm_minute;
  } out_t;

  // Input mode codes.
  localparam logic MODE_BYTE = 1'b0;
  localparam logic MODE_DONE = 1'b1;

  // Event codes.
  localparam logic [3:0] EV_MEASURE    = 4'd0;
  localparam logic [3:0] EV_TIMESYNC   = 4'd1;
  localparam logic [3:0] EV_DELAY      = 4'd2;
  localparam logic [3:0] EV_SLEEP      = 4'd3;
  localparam logic [3:0] EV_WAKEACK    = 4'd4;
  localparam logic [3:0] EV_THROUGHPUT = 4'd5;
  localparam logic [3:0] EV_RATIO      = 4'd6;
  localparam logic [3:0] EV_STATUS     = 4'd7;
  localparam logic [3:0] EV_ACK        = 4'd8;

  // Parser slots.
  localparam logic [3:0] SLOT_IDLE      = 4'd0;
  localparam logic [3:0] SLOT_CMD       = 4'd1;
  localparam logic [3:0] SLOT_TIME_FIRST = 4'd2;
  localparam logic [3:0] SLOT_TIME_LAST  = 4'd6;
  localparam logic [3:0] SLOT_TIME_EMIT  = 4'd7;
  localparam logic [3:0] SLOT_ACK_WAIT  = 4'd8;
  localparam logic [3:0] SLOT_ALARM_HR  = 4'd9;
  localparam logic [3:0] SLOT_ALARM_MIN = 4'd10;

  // Byte values.
  localparam logic [7:0] SYNC_BYTE = 8'd255;
  localparam logic [7:0] CH_A      = 8'h61;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_C      = 8'h63;
  localparam logic [7:0] CH_D      = 8'h64;
  localparam logic [7:0] CH_E      = 8'h65;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_G      = 8'h67;
  localparam logic [7:0] CH_H      = 8'h68;
  localparam logic [7:0] CH_ACK    = 8'h4B;

  // Number of held time bytes before the last one arrives.
  localparam int unsigned TIME_HELD = 5;

endpackage

`default_nettype wire

### hw/rtl/serial_command_frame_parser.sv
// ----------------------------------------------------------------------------
// serial_command_frame_parser
// Turns a stream of received serial bytes into command events.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (in_valid, in_ready, in_data) takes one beat per cycle:
// either a received byte (mode 0) or the ratio-test-done marker (mode 1).
// A byte of 255 always returns the parser to the command-letter slot.
// The output channel (out_valid, out_ready, out_data) carries one event beat
// for each byte that completes a command; other bytes give no beat.
// The event appears in the result register on the cycle after the byte
// that completes it is accepted.
// Throughput is one beat per cycle while the receiver does not stall.
// When the receiver stalls, the result register holds its beat and
// in_ready stays low until the beat is taken; with no pending beat, or a
// beat being taken in the same cycle, in_ready is high.
// Reset clears the slot, the ratio-test flag and the output valid; the held
// capture bytes are only read after they have been written.
// ----------------------------------------------------------------------------
`default_nettype none

module serial_command_frame_parser (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire scfp_pkg::in_t in_data,
  output logic               out_valid,
  input  wire logic          out_ready,
  output scfp_pkg::out_t     out_data
);

  import scfp_pkg::*;

  logic [3:0] slot;
  logic [3:0] slot_next;
  logic       ratio_active;
  logic       ratio_active_next;
  logic [7:0] held_time [TIME_HELD];
  logic [7:0] held_alarm_hour;
  logic       accept;
  logic       emit;
  logic       time_wr;
  logic       alarm_wr;
  logic [2:0] time_idx;
  out_t       result;

  // Handshake: the result register frees up when its beat is taken.
  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;
  assign time_idx = 3'(slot - SLOT_TIME_FIRST);

  // Slot update and result formation for one beat.
  always_comb begin
    slot_next         = slot;
    ratio_active_next = ratio_active;
    emit              = 1'b0;
    time_wr           = 1'b0;
    alarm_wr          = 1'b0;
    result            = '0;
    if (in_data.mode == MODE_DONE) begin
      ratio_active_next = 1'b0;
      slot_next         = SLOT_IDLE;
    end else if (slot == SLOT_CMD) begin
      case (in_data.rx_byte)
        CH_A: begin
          slot_next        = SLOT_IDLE;
          emit             = 1'b1;
          result.event_res = EV_MEASURE;
        end
        CH_B: begin
          slot_next = SLOT_TIME_FIRST;
        end
        CH_C: begin
          slot_next        = SLOT_ACK_WAIT;
          emit             = 1'b1;
          result.event_res = EV_DELAY;
        end
        CH_D: begin
          slot_next = SLOT_ALARM_HR;
        end
        CH_E: begin
          emit             = 1'b1;
          result.event_res = EV_WAKEACK;
        end
        CH_F: begin
          slot_next        = SLOT_ACK_WAIT;
          emit             = 1'b1;
          result.event_res = EV_THROUGHPUT;
        end
        CH_G: begin
          slot_next         = SLOT_ACK_WAIT;
          ratio_active_next = 1'b1;
          emit              = 1'b1;
          result.event_res  = EV_RATIO;
        end
        CH_H: begin
          slot_next        = SLOT_IDLE;
          emit             = 1'b1;
          result.event_res = EV_STATUS;
        end
        default: begin
          // Sync bytes and unknown letters keep waiting for a letter.
          slot_next = SLOT_CMD;
        end
      endcase
    end else if (in_data.rx_byte == SYNC_BYTE) begin
      // Resynchronize from any slot, including idle and unused ones.
      slot_next = SLOT_CMD;
    end else if (slot inside {[SLOT_TIME_FIRST:SLOT_TIME_LAST]}) begin
      time_wr   = 1'b1;
      slot_next = slot + 4'd1;
    end else begin
      case (slot)
        SLOT_TIME_EMIT: begin
          emit                = 1'b1;
          result.event_res    = EV_TIMESYNC;
          result.sync_hour    = held_time[0];
          result.sync_minute  = held_time[1];
          result.sync_second  = held_time[2];
          result.sync_day     = held_time[3];
          result.sync_month   = held_time[4];
          result.sync_year    = in_data.rx_byte;
          slot_next           = SLOT_IDLE;
        end
        SLOT_ACK_WAIT: begin
          if (in_data.rx_byte == CH_ACK) begin
            emit             = 1'b1;
            result.event_res = EV_ACK;
            slot_next        = ratio_active ? SLOT_ACK_WAIT : SLOT_IDLE;
          end
        end
        SLOT_ALARM_HR: begin
          alarm_wr  = 1'b1;
          slot_next = SLOT_ALARM_MIN;
        end
        SLOT_ALARM_MIN: begin
          emit                = 1'b1;
          result.event_res    = EV_SLEEP;
          result.alarm_hour   = held_alarm_hour;
          result.alarm_minute = in_data.rx_byte;
          slot_next           = SLOT_IDLE;
        end
        default: begin
          slot_next = slot;
        end
      endcase
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      slot         <= SLOT_IDLE;
      ratio_active <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (accept) begin
        slot         <= slot_next;
        ratio_active <= ratio_active_next;
      end
      if (accept && emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Captured bytes and the result register.
  always_ff @(posedge clk) begin
    if (accept && time_wr) begin
      held_time[time_idx] <= in_data.rx_byte;
    end
    if (accept && alarm_wr) begin
      held_alarm_hour <= in_data.rx_byte;
    end
    if (accept && emit) begin
      out_data <= result;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/scfp_checker.sv
// ----------------------------------------------------------------------------
// scfp_checker
// Port-level checks for the serial command frame parser, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

`include "serial_command_frame_parser_assert.svh"

module scfp_checker (
  input wire logic           clk,
  input wire logic           rst,
  input wire logic           in_valid,
  input wire logic           in_ready,
  input wire scfp_pkg::in_t  in_data,
  input wire logic           out_valid,
  input wire logic           out_ready,
  input wire scfp_pkg::out_t out_data
);

  import scfp_pkg::*;

  // A stalled result beat holds its payload.
  `SCFP_ASSERT(a_out_hold, (out_valid && !out_ready |=> out_valid && $stable(out_data)))

  // Reset leaves no result beat pending.
  `SCFP_ASSERT_ALWAYS(a_reset_clear, (rst |=> !out_valid))

  // A test-done beat never produces a result.
  `SCFP_ASSERT(a_done_silent, (in_valid && in_ready && in_data.mode |=> !out_valid))

  // With no result pending, the parser always takes input.
  `SCFP_ASSERT(a_ready_free, (!out_valid |-> in_ready))

  // Hour and year time fields are zero on every event other than time sync.
  `SCFP_ASSERT(a_sync_zero, (out_valid && out_data.event_res != EV_TIMESYNC |-> out_data.sync_hour == 8'd0 && out_data.sync_year == 8'd0))

endmodule

bind serial_command_frame_parser scfp_checker u_scfp_checker (.*);

`default_nettype wire

### tb/serial_command_frame_parser_test.sv
// ----------------------------------------------------------------------------
// serial_command_frame_parser_test
// Self-checking bench for the serial command frame parser. A directed table
// covers each command letter, resync, unknown letters, ignored bytes and the
// ratio-test done marker. Random frames follow, mostly well formed with
// random content, plus broken frames and noise, under three idling phases.
// Each event beat is checked field by field against a model or a table row.
// ----------------------------------------------------------------------------
`default_nettype none

module serial_command_frame_parser_test;
  import scfp_pkg::*;

  // How a stimulus beat's outcome is known.
  typedef enum logic [1:0] {
    CHK_MODEL,
    CHK_QUIET,
    CHK_EVENT
  } check_t;

  typedef struct {
    in_t        beat;
    check_t     check;
    logic [3:0] ev;
    int         src_idle;
    int         sink_stall;
  } stim_t;

  localparam int RANDOM_PER_PHASE = 220;
  localparam int TIMEOUT_CYCLES   = 300000;
  localparam int TAIL_CYCLES      = 4;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  // Parser model state.
  logic [3:0] slot_q = SLOT_IDLE;
  logic       ratio_on = 1'b0;
  logic [7:0] time_hold [TIME_HELD];
  logic [7:0] alarm_hold;

  stim_t pending_beats[$];
  stim_t directed_rows[$];
  out_t  expected_events[$];
  int    mismatches = 0;
  int    phase_src_idle = 28;
  int    phase_sink_stall = 58;
  int    sink_stall_pct = 58;

  serial_command_frame_parser dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #6 clk = ~clk;

  task automatic report_mismatch(input string msg);
    $display("%0t: mismatch: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [7:0] got,
                             input logic [7:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got %02h expected %02h", name, got, want));
    end
  endtask

  // Advance the parser model by one beat and give the event it causes.
  task automatic parse_beat(input in_t beat, output bit fires, output out_t res);
    logic [7:0] b;
    b = beat.rx_byte;
    fires = 1'b0;
    res = '0;
    if (beat.mode == MODE_DONE) begin
      ratio_on = 1'b0;
      slot_q = SLOT_IDLE;
    end else if (slot_q == SLOT_CMD) begin
      if (b != SYNC_BYTE) begin
        case (b)
          CH_A: begin
            slot_q = SLOT_IDLE;
            fires = 1'b1;
            res.event_res = EV_MEASURE;
          end
          CH_B: slot_q = SLOT_TIME_FIRST;
          CH_C: begin
            slot_q = SLOT_ACK_WAIT;
            fires = 1'b1;
            res.event_res = EV_DELAY;
          end
          CH_D: slot_q = SLOT_ALARM_HR;
          CH_E: begin
            fires = 1'b1;
            res.event_res = EV_WAKEACK;
          end
          CH_F: begin
            slot_q = SLOT_ACK_WAIT;
            fires = 1'b1;
            res.event_res = EV_THROUGHPUT;
          end
          CH_G: begin
            slot_q = SLOT_ACK_WAIT;
            ratio_on = 1'b1;
            fires = 1'b1;
            res.event_res = EV_RATIO;
          end
          CH_H: begin
            slot_q = SLOT_IDLE;
            fires = 1'b1;
            res.event_res = EV_STATUS;
          end
          default: ;
        endcase
      end
    end else if (slot_q >= SLOT_TIME_FIRST && slot_q <= SLOT_ALARM_MIN &&
                 b == SYNC_BYTE) begin
      slot_q = SLOT_CMD;
    end else if (slot_q >= SLOT_TIME_FIRST && slot_q <= SLOT_TIME_LAST) begin
      time_hold[3'(slot_q - SLOT_TIME_FIRST)] = b;
      slot_q = slot_q + 4'd1;
    end else if (slot_q == SLOT_TIME_EMIT) begin
      fires = 1'b1;
      res.event_res = EV_TIMESYNC;
      res.sync_hour = time_hold[0];
      res.sync_minute = time_hold[1];
      res.sync_second = time_hold[2];
      res.sync_day = time_hold[3];
      res.sync_month = time_hold[4];
      res.sync_year = b;
      slot_q = SLOT_IDLE;
    end else if (slot_q == SLOT_ACK_WAIT) begin
      if (b == CH_ACK) begin
        fires = 1'b1;
        res.event_res = EV_ACK;
        slot_q = ratio_on ? SLOT_ACK_WAIT : SLOT_IDLE;
      end
    end else if (slot_q == SLOT_ALARM_HR) begin
      alarm_hold = b;
      slot_q = SLOT_ALARM_MIN;
    end else if (slot_q == SLOT_ALARM_MIN) begin
      fires = 1'b1;
      res.event_res = EV_SLEEP;
      res.alarm_hour = alarm_hold;
      res.alarm_minute = b;
      slot_q = SLOT_IDLE;
    end else if (b == SYNC_BYTE) begin
      // Idle slot, and any slot value outside the legal set.
      slot_q = SLOT_CMD;
    end
  endtask

  function automatic stim_t make_row(input logic mode, input logic [7:0] b,
                                     input check_t check, input logic [3:0] ev);
    stim_t s;
    s.beat.mode = mode;
    s.beat.rx_byte = b;
    s.check = check;
    s.ev = ev;
    s.src_idle = phase_src_idle;
    s.sink_stall = phase_sink_stall;
    return s;
  endfunction

  function automatic stim_t row_model(input logic [7:0] b);
    return make_row(MODE_BYTE, b, CHK_MODEL, EV_MEASURE);
  endfunction

  function automatic stim_t row_quiet(input logic mode, input logic [7:0] b);
    return make_row(mode, b, CHK_QUIET, EV_MEASURE);
  endfunction

  function automatic stim_t row_event(input logic [7:0] b, input logic [3:0] ev);
    return make_row(MODE_BYTE, b, CHK_EVENT, ev);
  endfunction

  task automatic push_beat(input logic mode, input logic [7:0] b);
    pending_beats.push_back(make_row(mode, b, CHK_MODEL, EV_MEASURE));
  endtask

  // Optional noise bytes, then the acknowledge letter.
  task automatic push_ack_wait();
    repeat ($urandom_range(0, 2)) push_beat(MODE_BYTE, 8'($urandom_range(0, 254)));
    push_beat(MODE_BYTE, CH_ACK);
  endtask

  // Random frames until about target beats of well-formed frames are queued.
  task automatic gen_phase(input int target);
    int framed;
    int kind;
    int start;
    framed = 0;
    while (framed < target) begin
      kind = $urandom_range(0, 99);
      start = pending_beats.size();
      if (kind < 80) begin
        push_beat(MODE_BYTE, SYNC_BYTE);
        case ($urandom_range(0, 7))
          0: push_beat(MODE_BYTE, CH_A);
          1: begin
            push_beat(MODE_BYTE, CH_B);
            repeat (6) push_beat(MODE_BYTE, 8'($urandom_range(0, 254)));
          end
          2: begin
            push_beat(MODE_BYTE, CH_C);
            push_ack_wait();
          end
          3: begin
            push_beat(MODE_BYTE, CH_D);
            repeat (2) push_beat(MODE_BYTE, 8'($urandom_range(0, 254)));
          end
          4: repeat ($urandom_range(1, 3)) push_beat(MODE_BYTE, CH_E);
          5: begin
            push_beat(MODE_BYTE, CH_F);
            push_ack_wait();
          end
          6: begin
            push_beat(MODE_BYTE, CH_G);
            repeat ($urandom_range(1, 4)) push_ack_wait();
            if ($urandom_range(0, 4) != 0) begin
              push_beat(MODE_DONE, 8'($urandom_range(0, 255)));
            end
          end
          default: push_beat(MODE_BYTE, CH_H);
        endcase
        framed += pending_beats.size() - start;
      end else if (kind < 92) begin
        // Capture ended by a resync or the done marker; time capture is cut short.
        push_beat(MODE_BYTE, SYNC_BYTE);
        push_beat(MODE_BYTE, ($urandom_range(0, 1) != 0) ? CH_B : CH_D);
        repeat ($urandom_range(0, 4)) push_beat(MODE_BYTE, 8'($urandom_range(0, 254)));
        if ($urandom_range(0, 1) != 0) begin
          push_beat(MODE_BYTE, SYNC_BYTE);
          push_beat(MODE_BYTE, 8'($urandom_range(0, 255)));
        end else begin
          push_beat(MODE_DONE, 8'($urandom_range(0, 255)));
        end
      end else begin
        repeat ($urandom_range(1, 4)) begin
          push_beat(($urandom_range(0, 9) == 0) ? MODE_DONE : MODE_BYTE,
                    8'($urandom_range(0, 255)));
        end
      end
    end
  endtask

  // Drive both channels, run the model on each accepted input beat and
  // check each accepted event beat.
  always @(posedge clk) begin
    bit   fires;
    out_t predicted;
    out_t want;
    if (rst) begin
      in_valid <= 1'b0;
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_events.size() == 0) begin
          report_mismatch($sformatf("event beat %0d with none expected",
                                    out_data.event_res));
        end else begin
          want = expected_events.pop_front();
          check_field("event_res", 8'(out_data.event_res), 8'(want.event_res));
          check_field("sync_hour", out_data.sync_hour, want.sync_hour);
          check_field("sync_minute", out_data.sync_minute, want.sync_minute);
          check_field("sync_second", out_data.sync_second, want.sync_second);
          check_field("sync_day", out_data.sync_day, want.sync_day);
          check_field("sync_month", out_data.sync_month, want.sync_month);
          check_field("sync_year", out_data.sync_year, want.sync_year);
          check_field("alarm_hour", out_data.alarm_hour, want.alarm_hour);
          check_field("alarm_minute", out_data.alarm_minute, want.alarm_minute);
        end
      end

      if (in_valid && in_ready) begin
        parse_beat(pending_beats[0].beat, fires, predicted);
        if (pending_beats[0].check == CHK_MODEL) begin
          if (fires) expected_events.push_back(predicted);
        end else if (pending_beats[0].check == CHK_EVENT) begin
          predicted = '0;
          predicted.event_res = pending_beats[0].ev;
          expected_events.push_back(predicted);
        end
        sink_stall_pct = pending_beats[0].sink_stall;
        void'(pending_beats.pop_front());
      end

      out_ready <= ($urandom_range(0, 99) >= sink_stall_pct);

      // A presented beat holds until taken; otherwise present the next one.
      if (!(in_valid && !in_ready)) begin
        if (pending_beats.size() != 0 &&
            $urandom_range(0, 99) >= pending_beats[0].src_idle) begin
          in_valid <= 1'b1;
          in_data <= pending_beats[0].beat;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  initial begin
    // Directed table: each letter, resync, ignored bytes and the done marker.
    directed_rows.push_back(row_quiet(MODE_DONE, SYNC_BYTE));
    directed_rows.push_back(row_quiet(MODE_BYTE, CH_A));
    directed_rows.push_back(row_quiet(MODE_BYTE, SYNC_BYTE));
    directed_rows.push_back(row_event(CH_A, EV_MEASURE));
    directed_rows.push_back(row_quiet(MODE_BYTE, SYNC_BYTE));
    directed_rows.push_back(row_event(CH_E, EV_WAKEACK));
    directed_rows.push_back(row_quiet(MODE_BYTE, 8'h00));
    directed_rows.push_back(row_event(CH_H, EV_STATUS));
    directed_rows.push_back(row_quiet(MODE_BYTE, SYNC_BYTE));
    directed_rows.push_back(row_quiet(MODE_BYTE, CH_B));
    directed_rows.push_back(row_model(8'h00));
    directed_rows.push_back(row_model(8'hFE));
    directed_rows.push_back(row_model(8'h5A));
    directed_rows.push_back(row_model(8'hA5));
    directed_rows.push_back(row_model(8'h01));
    directed_rows.push_back(row_model(8'hFE));
    directed_rows.push_back(row_quiet(MODE_BYTE, SYNC_BYTE));
    directed_rows.push_back(row_quiet(MODE_BYTE, CH_D));
    directed_rows.push_back(row_model(8'h00));
    directed_rows.push_back(row_model(8'hFE));
    directed_rows.push_back(row_quiet(MODE_BYTE, SYNC_BYTE));
    directed_rows.push_back(row_event(CH_C, EV_DELAY));
    directed_rows.push_back(row_quiet(MODE_BYTE, 8'h4A));
    directed_rows.push_back(row_event(CH_ACK, EV_ACK));
    directed_rows.push_back(row_quiet(MODE_BYTE, SYNC_BYTE));
    directed_rows.push_back(row_event(CH_F, EV_THROUGHPUT));
    directed_rows.push_back(row_quiet(MODE_BYTE, SYNC_BYTE));
    directed_rows.push_back(row_event(CH_G, EV_RATIO));
    directed_rows.push_back(row_event(CH_ACK, EV_ACK));
    directed_rows.push_back(row_event(CH_ACK, EV_ACK));
    directed_rows.push_back(row_quiet(MODE_DONE, 8'h00));
    foreach (directed_rows[i]) pending_beats.push_back(directed_rows[i]);

    // Random phases: slow receiver, then slow sender, then full rate.
    gen_phase(RANDOM_PER_PHASE);
    phase_src_idle = 58;
    phase_sink_stall = 28;
    gen_phase(RANDOM_PER_PHASE);
    phase_src_idle = 0;
    phase_sink_stall = 0;
    gen_phase(RANDOM_PER_PHASE);

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    while (pending_beats.size() != 0 || expected_events.size() != 0) begin
      @(posedge clk);
    end
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("serial_command_frame_parser_test OK");
    end else begin
      $display("serial_command_frame_parser_test NOT OK");
    end
    $finish;
  end

  // Watchdog for a hung handshake or a missing event beat.
  initial begin
    #(12 * TIMEOUT_CYCLES);
    $display("serial_command_frame_parser_test NOT OK");
    $finish;
  end

endmodule

`default_nettype wire

### serial_command_frame_parser.f
+incdir+hw/rtl
hw/rtl/scfp_pkg.sv
hw/rtl/serial_command_frame_parser.sv
hw/rtl/scfp_checker.sv
tb/serial_command_frame_parser_test.sv
